/* sv/tbs_pkg.sv */
// Shared types and constants for the token bucket packet shaper.
package tbs_pkg;

  localparam int QUEUE_DEPTH_DEF = 64;

  localparam logic [7:0] BUCKET_DEPTH_RST = 8'd10;

  localparam int CFG_ADDR_W = 3;

  // register index, taken from the word address
  localparam logic REG_BUCKET_DEPTH = 1'b0;

  localparam logic ACT_TICK   = 1'b0;
  localparam logic ACT_PACKET = 1'b1;

  typedef enum logic [2:0] {
    ST_TOKEN_ADDED   = 3'd0,
    ST_TOKEN_DROPPED = 3'd1,
    ST_QUEUED        = 3'd2,
    ST_TOO_BIG       = 3'd3,
    ST_FIFO_FULL     = 3'd4
  } status_t;

  typedef struct packed {
    logic        action;
    logic [15:0] packet_id;
    logic [7:0]  tokens_needed;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic        released;
    logic [15:0] released_id;
    logic [7:0]  bucket_level;
    logic [6:0]  queue_count;
  } out_item_t;

  typedef struct packed {
    logic [7:0]  need;
    logic [15:0] id;
  } entry_t;

endpackage

/* sv/tbs_queue.sv */
// Packet queue storage: one-port-write memory with a registered head read and write bypass.
module tbs_queue
  import tbs_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF,
  localparam int PTR_W = $clog2(QUEUE_DEPTH)
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [PTR_W-1:0] wr_addr,
  input  entry_t           wr_data,
  input  logic [PTR_W-1:0] rd_addr,
  output entry_t           head_entry
);

  entry_t mem [QUEUE_DEPTH];
  entry_t rd_data_r;
  entry_t byp_data_r;
  logic   byp_valid_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // The read above sees old contents when the same entry is written this cycle.
  always_ff @(posedge clk) begin
    byp_valid_r <= wr_en && (wr_addr == rd_addr);
    byp_data_r  <= wr_data;
  end

  assign head_entry = byp_valid_r ? byp_data_r : rd_data_r;

endmodule

/* sv/token_bucket_packet_shaper_top.sv */
// Top level of the token bucket packet shaper: event logic, bucket and queue control.
//
// Usage
//   Input channel (in_valid/in_ready/in_data): one event per transfer, either a
//   token tick or a packet arrival carrying an id and its token need.
//   Result channel (out_valid/out_ready/out_data): exactly one result per event,
//   giving the event status, the packet released (if any), the bucket level
//   and the queue occupancy after the event.
//   Config port (APB, pready tied high): bucket depth at byte address 0.
//   Write it only while no event is in flight.
//
// Timing
//   One event per cycle sustained while the receiver takes each result. The
//   result is registered on the input transfer. The rate is held by keeping
//   the queue head available every cycle: the memory read is registered at
//   the next head pointer, with a bypass for an entry written in the same cycle.
//
// Reset and stalls
//   Reset empties the queue, clears the bucket and loads a depth of 10.
//   When the receiver stalls, the result is held and in_ready stays high only
//   if the output register is about to be freed; events are never lost.
module token_bucket_packet_shaper_top
  import tbs_pkg::*;
#(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output out_item_t             out_data,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [31:0]           pwdata,
  output logic [31:0]           prdata,
  output logic                  pready
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);

  logic [7:0]       depth_r;
  logic [7:0]       token_r, token_nxt;
  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic [OCC_W-1:0] occ_r, occ_nxt;
  logic             out_valid_r, out_valid_nxt;
  out_item_t        out_data_r, result;

  logic             fire;
  logic             wr_en;
  entry_t           wr_data;
  entry_t           head_entry;
  entry_t           rel_entry;
  logic             rel;
  logic [7:0]       token_mid;
  logic [31:0]      occ_ext;

  // ---------------------------------------------------------------------------
  // Config port: a single register, decoded on the word address bit.
  // ---------------------------------------------------------------------------
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= BUCKET_DEPTH_RST;
    end else if (psel && penable && pwrite && (paddr[2] == REG_BUCKET_DEPTH)) begin
      depth_r <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_BUCKET_DEPTH) ? {24'd0, depth_r} : 32'd0;

  // ---------------------------------------------------------------------------
  // Handshake: take a new event whenever the output register is free or being
  // drained in this cycle.
  // ---------------------------------------------------------------------------
  assign in_ready = !out_valid_r || out_ready;
  assign fire     = in_valid && in_ready;

  // ---------------------------------------------------------------------------
  // Event logic. A tick first fills the bucket, then tries the head packet. An
  // arrival is checked for size, then for room; it only leaves at once when it
  // lands in an empty queue, in which case it is its own head.
  // ---------------------------------------------------------------------------
  assign wr_data.need = in_data.tokens_needed;
  assign wr_data.id   = in_data.packet_id;

  always_comb begin
    result        = '0;
    wr_en         = 1'b0;
    rel           = 1'b0;
    rel_entry     = head_entry;
    token_mid     = token_r;
    result.status = ST_TOKEN_DROPPED;

    if (in_data.action == ACT_TICK) begin
      if (token_r < depth_r) begin
        token_mid     = token_r + 8'd1;
        result.status = ST_TOKEN_ADDED;
      end
      rel = (occ_r != '0) && (token_mid >= head_entry.need);
    end else if (in_data.tokens_needed > depth_r) begin
      result.status = ST_TOO_BIG;
    end else if (occ_r == OCC_W'(QUEUE_DEPTH)) begin
      result.status = ST_FIFO_FULL;
    end else begin
      wr_en         = 1'b1;
      result.status = ST_QUEUED;
      rel_entry     = wr_data;
      rel           = (occ_r == '0) && (token_r >= in_data.tokens_needed);
    end

    // hold all state unless an event is taken
    wr_en = wr_en && fire;
    rel   = rel && fire;

    token_nxt = fire ? token_mid : token_r;
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    if (rel) begin
      token_nxt = token_mid - rel_entry.need;
      head_nxt  = (head_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_r + PTR_W'(1);
    end
    if (wr_en) begin
      tail_nxt  = (tail_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_r + PTR_W'(1);
    end
    occ_nxt = occ_r + OCC_W'(wr_en) - OCC_W'(rel);

    occ_ext             = 32'(occ_nxt);
    result.released     = rel;
    result.released_id  = rel ? rel_entry.id : 16'd0;
    result.bucket_level = token_nxt;
    result.queue_count  = occ_ext[6:0];
  end

  // ---------------------------------------------------------------------------
  // Queue storage; the read address follows the next head so the head entry is
  // ready for the following event.
  // ---------------------------------------------------------------------------
  tbs_queue #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk        (clk),
    .wr_en      (wr_en),
    .wr_addr    (tail_r),
    .wr_data    (wr_data),
    .rd_addr    (head_nxt),
    .head_entry (head_entry)
  );

  // ---------------------------------------------------------------------------
  // State and output registers.
  // ---------------------------------------------------------------------------
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      token_r     <= '0;
      head_r      <= '0;
      tail_r      <= '0;
      occ_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      token_r     <= token_nxt;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      occ_r       <= occ_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // load the result on each transfer, hold it while the receiver stalls
  always_ff @(posedge clk) begin
    if (fire) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

/* sv/tbs_checker.sv */
// Port-level checker for the token bucket packet shaper, bound to the top level.
module tbs_checker
  import tbs_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      out_valid,
  input logic      out_ready,
  input out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed or dropped while stalled");

  // no release id without a release
  a_id_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.released |-> out_data.released_id == 16'd0)
    else $error("released_id set without a release");

  // a dropped arrival never releases
  a_drop_no_rel: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == ST_TOO_BIG || out_data.status == ST_FIFO_FULL)
    |-> !out_data.released)
    else $error("release on a dropped arrival");

  // reset empties the result channel
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind token_bucket_packet_shaper_top tbs_checker u_tbs_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);
